// ===== design/dpr_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helper functions for the bitmap pixel to rgba unit
// no dependencies; imported by every module of the block

package dpr_pkg;

    // pipeline depth: input register, mask scan, run length, reciprocal multiply, correction
    localparam int NUM_STAGES  = 5;
    localparam int CFG_INDEX_W = 3;
    localparam int WORD_W      = 32;
    localparam int CHAN_W      = 8;
    localparam int RUN_W       = 6;
    localparam int K_W         = 3;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PIXEL_MODE = 3'd0,
        REG_RED_MASK   = 3'd1,
        REG_GREEN_MASK = 3'd2,
        REG_BLUE_MASK  = 3'd3,
        REG_ALPHA_MASK = 3'd4
    } cfg_reg_t;

    // fixed byte order masks, also the reset masks
    localparam logic [WORD_W-1:0] FIXED_RED_MASK   = 32'h00FF_0000;
    localparam logic [WORD_W-1:0] FIXED_GREEN_MASK = 32'h0000_FF00;
    localparam logic [WORD_W-1:0] FIXED_BLUE_MASK  = 32'h0000_00FF;
    localparam logic [WORD_W-1:0] NO_MASK          = 32'h0000_0000;

    localparam logic [CHAN_W-1:0] OPAQUE_ALPHA = 8'hFF;
    localparam logic [CHAN_W-1:0] CHAN_ZERO    = 8'h00;

    // floor((2^32-1) / (2^k-1)) for run widths k = 1..7; the estimate is low by at most one
    localparam logic [WORD_W-1:0] RECIP_TABLE [8] = '{
        32'h0000_0000,
        32'hFFFF_FFFF,
        32'h5555_5555,
        32'h2492_4924,
        32'h1111_1111,
        32'h0842_1084,
        32'h0410_4104,
        32'h0204_0810
    };

    // pipeline load enables, one per stage
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctrl_t;

    // count of trailing zeros, 32 when the word is zero
    function automatic logic [RUN_W-1:0] ctz32(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] v;
        logic [RUN_W-1:0]  n;
        v = x;
        n = '0;
        if (v[15:0] == 16'h0000)
        begin
            n = n + 6'd16;
            v = v >> 16;
        end
        if (v[7:0] == 8'h00)
        begin
            n = n + 6'd8;
            v = v >> 8;
        end
        if (v[3:0] == 4'h0)
        begin
            n = n + 6'd4;
            v = v >> 4;
        end
        if (v[1:0] == 2'b00)
        begin
            n = n + 6'd2;
            v = v >> 2;
        end
        if (v[0] == 1'b0)
        begin
            n = n + 6'd1;
        end
        if (x == '0)
        begin
            n = 6'd32;
        end
        return n;
    endfunction

    // divisor 2^k-1 for a narrow run width
    function automatic logic [CHAN_W-1:0] run_divisor(input logic [K_W-1:0] k);
        logic [CHAN_W-1:0] d;
        d = (8'd1 << k) - 8'd1;
        return d;
    endfunction

endpackage

// ===== design/dpr_pipe_ctrl.sv =====
`timescale 1ns / 1ps
// pipeline control: per-stage valid bits and load enables with bubble collapse
// depends on dpr_pkg

module dpr_pipe_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                out_stall,
    output logic                in_stall,
    output logic                out_valid,
    output dpr_pkg::pipe_ctrl_t ctrl
);
    import dpr_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] load;

    // a stage may load when it is empty or its content moves on
    always_comb
    begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !out_stall;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    // valid bits travel with the data
    always_comb
    begin
        valid_next = valid_reg;
        if (load[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (load[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.load = load;
    assign in_stall  = !load[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    // input is held off only when every stage holds an item
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&valid_reg))
        else $error("input stalled while the pipeline has a free stage");

    // with a free output the block always takes a transfer
    a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled although the output is not stalled");

    // an item in the first stage that may move shows up in the second
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[0] && load[1]) |=> valid_reg[1])
        else $error("item lost between the first and second stage");

endmodule

// ===== design/dpr_chan_unit.sv =====
`timescale 1ns / 1ps
// one color channel: mask scan, run length, scaling by 255/(2^k-1) and correction
// depends on dpr_pkg; stage load enables come from dpr_pipe_ctrl

module dpr_chan_unit (
    input  logic                        clk,
    input  dpr_pkg::pipe_ctrl_t         ctrl,
    input  logic [dpr_pkg::WORD_W-1:0]  pixel,
    input  logic [dpr_pkg::WORD_W-1:0]  mask,
    input  logic [dpr_pkg::CHAN_W-1:0]  fill_value,
    output logic [dpr_pkg::CHAN_W-1:0]  chan
);
    import dpr_pkg::*;

    // stage 2: shifted mask and value
    logic [WORD_W-1:0] s2_smask_reg, s2_smask_next;
    logic [WORD_W-1:0] s2_val_reg, s2_val_next;
    logic              s2_zero_reg, s2_zero_next;
    logic [RUN_W-1:0]  pos;

    // stage 3: direct byte or value times 255
    logic [CHAN_W-1:0] s3_byte_reg, s3_byte_next;
    logic              s3_direct_reg, s3_direct_next;
    logic [WORD_W-1:0] s3_x_reg, s3_x_next;
    logic [K_W-1:0]    s3_k_reg, s3_k_next;
    logic [RUN_W-1:0]  run;
    logic [4:0]        shamt;
    logic [WORD_W-1:0] wide_val;

    // stage 4: quotient estimate
    logic [CHAN_W-1:0] s4_byte_reg, s4_byte_next;
    logic              s4_direct_reg, s4_direct_next;
    logic [CHAN_W-1:0] s4_q_reg, s4_q_next;
    logic [CHAN_W-1:0] s4_x_reg, s4_x_next;
    logic [K_W-1:0]    s4_k_reg, s4_k_next;
    logic [2*WORD_W-1:0] prod;

    // stage 5: output byte
    logic [CHAN_W-1:0] chan_reg, chan_next;
    logic [CHAN_W-1:0] div;
    logic [CHAN_W-1:0] rem;
    logic [CHAN_W-1:0] qd;

    // lowest set bit of the mask and the value moved down to it
    always_comb
    begin
        pos           = ctz32(mask);
        s2_smask_next = mask >> pos[4:0];
        s2_val_next   = (pixel & mask) >> pos[4:0];
        s2_zero_next  = (mask == '0);
    end

    // run of ones, wide runs take the top eight bits, narrow runs get times 255
    always_comb
    begin
        run            = ctz32(~s2_smask_reg);
        shamt          = 5'(run - 6'd8);
        wide_val       = s2_val_reg >> shamt;
        s3_x_next      = (s2_val_reg << 8) - s2_val_reg;
        s3_k_next      = run[K_W-1:0];
        s3_byte_next   = wide_val[CHAN_W-1:0];
        s3_direct_next = 1'b1;
        if (s2_zero_reg)
        begin
            s3_byte_next = fill_value;
        end
        else if (run < 6'd8)
        begin
            s3_direct_next = 1'b0;
        end
    end

    // reciprocal multiply, keep the low byte of the high word
    always_comb
    begin
        prod           = 64'(s3_x_reg) * 64'(RECIP_TABLE[s3_k_reg]);
        s4_q_next      = prod[WORD_W+CHAN_W-1:WORD_W];
        s4_x_next      = s3_x_reg[CHAN_W-1:0];
        s4_k_next      = s3_k_reg;
        s4_byte_next   = s3_byte_reg;
        s4_direct_next = s3_direct_reg;
    end

    // remainder stays below twice the divisor, so its low byte is exact
    always_comb
    begin
        div = run_divisor(s4_k_reg);
        qd  = 8'(s4_q_reg * div);
        rem = s4_x_reg - qd;
        if (s4_direct_reg)
        begin
            chan_next = s4_byte_reg;
        end
        else if (rem >= div)
        begin
            chan_next = s4_q_reg + 8'd1;
        end
        else
        begin
            chan_next = s4_q_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            s2_smask_reg <= s2_smask_next;
            s2_val_reg   <= s2_val_next;
            s2_zero_reg  <= s2_zero_next;
        end
        if (ctrl.load[2])
        begin
            s3_byte_reg   <= s3_byte_next;
            s3_direct_reg <= s3_direct_next;
            s3_x_reg      <= s3_x_next;
            s3_k_reg      <= s3_k_next;
        end
        if (ctrl.load[3])
        begin
            s4_byte_reg   <= s4_byte_next;
            s4_direct_reg <= s4_direct_next;
            s4_q_reg      <= s4_q_next;
            s4_x_reg      <= s4_x_next;
            s4_k_reg      <= s4_k_next;
        end
        if (ctrl.load[4])
        begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

// ===== design/dib_pixel_to_rgba_unit.sv =====
`timescale 1ns / 1ps
// pipeline: a result passes five register stages after its input transfer
// throughput: one pixel per cycle while the output is not stalled; the reciprocal multiply stage is fully pipelined
// stalls collapse bubbles, so input is held off only when all five stages are full
// reset: asynchronous, active low; clears valid bits and loads the fixed-mode masks
// depends on dpr_pkg, dpr_pipe_ctrl, dpr_chan_unit

module dib_pixel_to_rgba_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [dpr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dpr_pkg::WORD_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [dpr_pkg::WORD_W-1:0]        pixel_word,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [dpr_pkg::CHAN_W-1:0]        red,
    output logic [dpr_pkg::CHAN_W-1:0]        green,
    output logic [dpr_pkg::CHAN_W-1:0]        blue,
    output logic [dpr_pkg::CHAN_W-1:0]        alpha
);
    import dpr_pkg::*;

    logic              mode_reg;
    logic [WORD_W-1:0] red_mask_reg;
    logic [WORD_W-1:0] green_mask_reg;
    logic [WORD_W-1:0] blue_mask_reg;
    logic [WORD_W-1:0] alpha_mask_reg;
    logic [WORD_W-1:0] pixel_reg;
    logic [WORD_W-1:0] red_eff;
    logic [WORD_W-1:0] green_eff;
    logic [WORD_W-1:0] blue_eff;
    logic [WORD_W-1:0] alpha_eff;
    pipe_ctrl_t        ctrl;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            red_mask_reg   <= FIXED_RED_MASK;
            green_mask_reg <= FIXED_GREEN_MASK;
            blue_mask_reg  <= FIXED_BLUE_MASK;
            alpha_mask_reg <= NO_MASK;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PIXEL_MODE: mode_reg       <= cfg_data[0];
                REG_RED_MASK:   red_mask_reg   <= cfg_data;
                REG_GREEN_MASK: green_mask_reg <= cfg_data;
                REG_BLUE_MASK:  blue_mask_reg  <= cfg_data;
                REG_ALPHA_MASK: alpha_mask_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // fixed mode is the byte masks with no alpha mask
    always_comb
    begin
        red_eff   = mode_reg ? red_mask_reg   : FIXED_RED_MASK;
        green_eff = mode_reg ? green_mask_reg : FIXED_GREEN_MASK;
        blue_eff  = mode_reg ? blue_mask_reg  : FIXED_BLUE_MASK;
        alpha_eff = mode_reg ? alpha_mask_reg : NO_MASK;
    end

    // stage 1: input register
    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            pixel_reg <= pixel_word;
        end
    end

    dpr_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .ctrl      (ctrl)
    );

    dpr_chan_unit u_red (
        .clk        (clk),
        .ctrl       (ctrl),
        .pixel      (pixel_reg),
        .mask       (red_eff),
        .fill_value (CHAN_ZERO),
        .chan       (red)
    );

    dpr_chan_unit u_green (
        .clk        (clk),
        .ctrl       (ctrl),
        .pixel      (pixel_reg),
        .mask       (green_eff),
        .fill_value (CHAN_ZERO),
        .chan       (green)
    );

    dpr_chan_unit u_blue (
        .clk        (clk),
        .ctrl       (ctrl),
        .pixel      (pixel_reg),
        .mask       (blue_eff),
        .fill_value (CHAN_ZERO),
        .chan       (blue)
    );

    // a zero alpha mask reads as opaque
    dpr_chan_unit u_alpha (
        .clk        (clk),
        .ctrl       (ctrl),
        .pixel      (pixel_reg),
        .mask       (alpha_eff),
        .fill_value (OPAQUE_ALPHA),
        .chan       (alpha)
    );

endmodule
